### sv/plvd_pkg.sv
// package for the posting list delta varint encoder
// holds widths, item codes, the queued job type and status structs; no dependencies
package plvd_pkg;

    // width of every encoded number; inputs are cut or zero-extended to it
    localparam int VALUE_WIDTH = 32;
    // fixed width of the input value fields
    localparam int FIELD_WIDTH = 32;
    // bits of payload carried by one output byte
    localparam int GROUP_BITS  = 7;
    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [FIELD_WIDTH-1:0] field_t;
    typedef logic [PTR_WIDTH-1:0]   ptr_t;
    typedef logic [CNT_WIDTH-1:0]   cnt_t;

    // item kinds
    typedef enum logic
    {
        FUNC_HEADER = 1'b0,
        FUNC_LINE   = 1'b1
    } func_t;

    // one classified item: one or two numbers to serialize
    typedef struct packed
    {
        value_t first_value;
        value_t second_value;
        logic   has_second;
    } job_t;

    // queue status toward front and back
    typedef struct packed
    {
        logic full;
        logic not_empty;
    } queue_status_t;

    // back engine status
    typedef struct packed
    {
        logic busy;
        logic pop;
    } back_status_t;

endpackage

### sv/posting_list_delta_varint_encoder_core.sv
// posting list delta varint encoder, top level
// path to the first byte: queue entry, back value register, output byte register
// throughput: one output byte per cycle from the back serializer while out_stall is low;
// a line item gives 1 to 5 bytes, a header 2 to 10 (one per 7-bit group)
// the 2-entry job queue lets the front accept while the back is still sending
// reset: asynchronous active low; clears delta state, queue and output valid
module posting_list_delta_varint_encoder_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [0:0]       func,
    input  logic [0:0]       first_in_list,
    input  plvd_pkg::field_t doc_id,
    input  plvd_pkg::field_t line_count,
    input  plvd_pkg::field_t line_number,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             last
);
    import plvd_pkg::*;

    logic          push;
    job_t          push_job;
    job_t          pop_job;
    queue_status_t q_status;
    back_status_t  b_status;

    // delta coding front
    plvd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .first_in_list (first_in_list),
        .doc_id        (doc_id),
        .line_count    (line_count),
        .line_number   (line_number),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    // job queue
    plvd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (b_status.pop),
        .pop_job  (pop_job),
        .q_status (q_status)
    );

    // byte serializer
    plvd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_job   (pop_job),
        .b_status  (b_status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

`ifndef ASSERT_OFF
    // the final byte of an item always carries the stop bit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> out_byte[7])
        else $error("last byte without stop bit");

    // the back never takes a job from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        b_status.pop |-> q_status.not_empty)
        else $error("pop from empty queue");

    // an accepted item is held in the queue or being serialized next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (q_status.not_empty || b_status.busy))
        else $error("accepted item lost");
`endif

endmodule

### sv/plvd_front.sv
// front part: accepts items, applies delta coding and builds jobs
// depends on plvd_pkg
module plvd_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [0:0]             func,
    input  logic [0:0]             first_in_list,
    input  plvd_pkg::field_t       doc_id,
    input  plvd_pkg::field_t       line_count,
    input  plvd_pkg::field_t       line_number,
    input  plvd_pkg::queue_status_t q_status,
    output logic                   push,
    output plvd_pkg::job_t         push_job
);
    import plvd_pkg::*;

    value_t previous_doc_reg;
    value_t previous_doc_next;
    value_t previous_line_reg;
    value_t previous_line_next;
    logic   line_is_first_reg;
    logic   line_is_first_next;
    value_t doc_v;
    value_t count_v;
    value_t line_v;

    // accept whenever the queue has room
    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    // classify and delta-code the item
    always_comb
    begin
        doc_v              = value_t'(doc_id);
        count_v            = value_t'(line_count);
        line_v             = value_t'(line_number);
        previous_doc_next  = previous_doc_reg;
        previous_line_next = previous_line_reg;
        line_is_first_next = line_is_first_reg;
        if (func == FUNC_HEADER)
        begin
            push_job.first_value  = first_in_list[0] ? doc_v : doc_v - previous_doc_reg;
            push_job.second_value = count_v;
            push_job.has_second   = 1'b1;
            if (push)
            begin
                previous_doc_next  = doc_v;
                line_is_first_next = 1'b1;
            end
        end
        else
        begin
            push_job.first_value  = line_is_first_reg ? line_v : line_v - previous_line_reg;
            push_job.second_value = '0;
            push_job.has_second   = 1'b0;
            if (push)
            begin
                previous_line_next = line_v;
                line_is_first_next = 1'b0;
            end
        end
    end

    // delta state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_doc_reg  <= '0;
            previous_line_reg <= '0;
            line_is_first_reg <= 1'b1;
        end
        else
        begin
            previous_doc_reg  <= previous_doc_next;
            previous_line_reg <= previous_line_next;
            line_is_first_reg <= line_is_first_next;
        end
    end

endmodule

### sv/plvd_queue.sv
// short job queue between front and back
// depends on plvd_pkg
module plvd_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  plvd_pkg::job_t          push_job,
    input  logic                    pop,
    output plvd_pkg::job_t          pop_job,
    output plvd_pkg::queue_status_t q_status
);
    import plvd_pkg::*;

    job_t entries_reg [QUEUE_DEPTH];
    ptr_t wr_ptr_reg;
    ptr_t wr_ptr_next;
    ptr_t rd_ptr_reg;
    ptr_t rd_ptr_next;
    cnt_t count_reg;
    cnt_t count_next;

    assign pop_job            = entries_reg[rd_ptr_reg];
    assign q_status.full      = (count_reg == cnt_t'(QUEUE_DEPTH));
    assign q_status.not_empty = (count_reg != '0);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### sv/plvd_back.sv
// back part: serializes queued numbers into varint bytes, one byte a cycle while not stalled
// depends on plvd_pkg
module plvd_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  plvd_pkg::queue_status_t q_status,
    input  plvd_pkg::job_t          pop_job,
    output plvd_pkg::back_status_t  b_status,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              out_byte,
    output logic                    last
);
    import plvd_pkg::*;

    logic       busy_reg;
    logic       busy_next;
    value_t     cur_reg;
    value_t     cur_next;
    value_t     second_reg;
    value_t     second_next;
    logic       has_second_reg;
    logic       has_second_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       last_reg;
    logic       last_next;
    logic       advance;
    logic       stop;
    logic       finishing;
    logic       pop;
    value_t     rest;

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last          = last_reg;
    assign b_status.busy = busy_reg;
    assign b_status.pop  = pop;

    // emit one group per cycle while the output is not stalled, load the next job when idle or as the current one ends
    always_comb
    begin
        advance         = !out_valid_reg || !out_stall;
        rest            = cur_reg >> GROUP_BITS;
        stop            = (rest == '0);
        finishing       = busy_reg && stop && !has_second_reg;
        pop             = q_status.not_empty && (!busy_reg || (advance && finishing));
        busy_next       = busy_reg;
        cur_next        = cur_reg;
        second_next     = second_reg;
        has_second_next = has_second_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        last_next       = last_reg;
        if (advance)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                out_byte_next = {stop, cur_reg[GROUP_BITS-1:0]};
                last_next     = finishing;
                if (stop)
                begin
                    cur_next        = second_reg;
                    has_second_next = 1'b0;
                end
                else
                begin
                    cur_next = rest;
                end
                if (finishing)
                begin
                    busy_next = 1'b0;
                end
            end
        end
        if (pop)
        begin
            busy_next       = 1'b1;
            cur_next        = pop_job.first_value;
            second_next     = pop_job.second_value;
            has_second_next = pop_job.has_second;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        second_reg     <= second_next;
        has_second_reg <= has_second_next;
        out_byte_reg   <= out_byte_next;
        last_reg       <= last_next;
    end

endmodule
